// ===== hw/rtl/bfa_pkg.sv =====
`default_nettype none

package bfa_pkg;

    localparam int ElemWidth = 63;
    localparam int DegWidth  = 6;
    localparam int PolyWidth = 64;
    localparam int CntWidth  = 7;

    localparam logic [DegWidth-1:0]  DegreeReset = 6'd8;
    localparam logic [PolyWidth-1:0] PolyReset   = 64'd283;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_MUL = 2'd1,
        CMD_INV = 2'd2,
        CMD_NOP = 2'd3
    } cmd_t;

    typedef enum logic {
        CFG_FIELD_DEGREE   = 1'b0,
        CFG_REDUCTION_POLY = 1'b1
    } cfg_index_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [ElemWidth-1:0] operand_a;
        logic [ElemWidth-1:0] operand_b;
    } request_t;

    typedef struct packed {
        logic [ElemWidth-1:0] value;
        logic                 no_inverse;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_XOR,
        ST_NOP,
        ST_MUL,
        ST_INV_LEN,
        ST_INV_UPD
    } state_t;

    typedef enum logic [1:0] {
        SEL_XOR,
        SEL_ACC,
        SEL_ZERO,
        SEL_FAIL
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_step;
        logic     len_step;
        logic     inv_step;
        logic     finish;
        res_sel_t res_sel;
    } ctrl_t;

    typedef struct packed {
        logic mul_last;
        logic u_one;
        logic u_zero;
        logic inv_first;
        logic cap_hit;
    } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfa_ctrl.sv =====
`default_nettype none

module bfa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire bfa_pkg::cmd_t cmd,
    input  wire bfa_pkg::stat_t stat,
    output bfa_pkg::ctrl_t     ctrl,
    output logic               busy
);

    bfa_pkg::state_t state_reg;
    bfa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bfa_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        bfa_pkg::CMD_ADD: state_next = bfa_pkg::ST_XOR;
                        bfa_pkg::CMD_MUL: state_next = bfa_pkg::ST_MUL;
                        bfa_pkg::CMD_INV: state_next = bfa_pkg::ST_INV_LEN;
                        default:          state_next = bfa_pkg::ST_NOP;
                    endcase
                end
            end
            bfa_pkg::ST_XOR,
            bfa_pkg::ST_NOP:
            begin
                state_next = bfa_pkg::ST_IDLE;
            end
            bfa_pkg::ST_MUL:
            begin
                if (stat.mul_last)
                begin
                    state_next = bfa_pkg::ST_IDLE;
                end
            end
            bfa_pkg::ST_INV_LEN:
            begin
                priority if (stat.u_one)
                begin
                    state_next = bfa_pkg::ST_IDLE;
                end
                else if ((stat.inv_first && stat.u_zero) || stat.cap_hit)
                begin
                    state_next = bfa_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = bfa_pkg::ST_INV_UPD;
                end
            end
            bfa_pkg::ST_INV_UPD:
            begin
                state_next = bfa_pkg::ST_INV_LEN;
            end
            default:
            begin
                state_next = bfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl         = '0;
        ctrl.res_sel = bfa_pkg::SEL_ZERO;
        busy         = 1'b1;
        unique case (state_reg)
            bfa_pkg::ST_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            bfa_pkg::ST_XOR:
            begin
                ctrl.finish  = 1'b1;
                ctrl.res_sel = bfa_pkg::SEL_XOR;
            end
            bfa_pkg::ST_NOP:
            begin
                ctrl.finish  = 1'b1;
                ctrl.res_sel = bfa_pkg::SEL_ZERO;
            end
            bfa_pkg::ST_MUL:
            begin
                ctrl.finish   = stat.mul_last;
                ctrl.mul_step = !stat.mul_last;
                ctrl.res_sel  = bfa_pkg::SEL_ACC;
            end
            bfa_pkg::ST_INV_LEN:
            begin
                // u == 1 is tested before the zero operand and the round cap
                priority if (stat.u_one)
                begin
                    ctrl.finish  = 1'b1;
                    ctrl.res_sel = bfa_pkg::SEL_ACC;
                end
                else if ((stat.inv_first && stat.u_zero) || stat.cap_hit)
                begin
                    ctrl.finish  = 1'b1;
                    ctrl.res_sel = bfa_pkg::SEL_FAIL;
                end
                else
                begin
                    ctrl.len_step = 1'b1;
                end
            end
            bfa_pkg::ST_INV_UPD:
            begin
                ctrl.inv_step = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bfa_datapath.sv =====
`default_nettype none

module bfa_datapath (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire bfa_pkg::request_t                  request,
    input  wire logic [bfa_pkg::DegWidth-1:0]       degree,
    input  wire logic [bfa_pkg::PolyWidth-1:0]      poly,
    input  wire bfa_pkg::ctrl_t                     ctrl,
    output bfa_pkg::stat_t                          stat,
    output logic                                    done,
    output bfa_pkg::result_t                        result
);

    localparam int W = bfa_pkg::PolyWidth;
    localparam int C = bfa_pkg::CntWidth;

    function automatic logic [C-1:0] bit_len(input logic [W-1:0] x);
        logic [C-1:0] n;
        n = '0;
        for (int i = 0; i < W; i++)
        begin
            if (x[i])
            begin
                n = C'(i + 1);
            end
        end
        return n;
    endfunction

    // u: operand a (shifted right during multiply) or Euclid u
    // v: shifted operand b during multiply or Euclid v
    // g1: product accumulator or Euclid g1
    logic [W-1:0] u_reg, u_next;
    logic [W-1:0] v_reg, v_next;
    logic [W-1:0] g1_reg, g1_next;
    logic [W-1:0] g2_reg, g2_next;
    logic [C-1:0] lu_reg, lu_next;
    logic [C-1:0] lv_reg, lv_next;
    logic [C-1:0] cnt_reg, cnt_next;
    logic         done_reg;
    bfa_pkg::result_t result_reg;
    bfa_pkg::result_t result_next;

    logic [W-1:0] poly_mask;
    logic [W-1:0] emask;
    logic [W-1:0] poly_m;
    logic [W-1:0] a_m;
    logic [W-1:0] b_m;
    logic [W-1:0] b_sh;
    logic [W-1:0] b_red;
    logic         b_top;
    logic         lu_lt;
    logic [C-1:0] shift_amt;

    assign poly_mask = {W{1'b1}} >> (6'd63 - degree);
    assign emask     = poly_mask >> 1;
    assign poly_m    = poly & poly_mask;
    assign a_m       = {1'b0, request.operand_a} & emask;
    assign b_m       = {1'b0, request.operand_b} & emask;

    assign b_top = v_reg[degree - 6'd1];
    assign b_sh  = {v_reg[W-2:0], 1'b0};
    assign b_red = (b_sh ^ (b_top ? poly_m : '0)) & emask;

    assign lu_lt     = lu_reg < lv_reg;
    assign shift_amt = lu_lt ? (lv_reg - lu_reg) : (lu_reg - lv_reg);

    always_comb
    begin
        u_next   = u_reg;
        v_next   = v_reg;
        g1_next  = g1_reg;
        g2_next  = g2_reg;
        lu_next  = lu_reg;
        lv_next  = lv_reg;
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            u_next  = a_m;
            g2_next = '0;
            if (request.cmd == bfa_pkg::CMD_INV)
            begin
                v_next   = poly_m;
                g1_next  = W'(1);
                cnt_next = '0;
            end
            else
            begin
                v_next   = b_m;
                g1_next  = a_m[0] ? b_m : '0;
                cnt_next = C'(1);
            end
        end
        else if (ctrl.mul_step)
        begin
            v_next   = b_red;
            g1_next  = g1_reg ^ (u_reg[1] ? b_red : '0);
            u_next   = u_reg >> 1;
            cnt_next = cnt_reg + C'(1);
        end
        else if (ctrl.len_step)
        begin
            lu_next  = bit_len(u_reg);
            lv_next  = bit_len(v_reg);
            cnt_next = cnt_reg + C'(1);
        end
        else if (ctrl.inv_step)
        begin
            // shifts of W or more give zero
            if (lu_lt)
            begin
                u_next  = v_reg ^ (u_reg << shift_amt);
                v_next  = u_reg;
                g1_next = g2_reg ^ (g1_reg << shift_amt);
                g2_next = g1_reg;
            end
            else
            begin
                u_next  = u_reg ^ (v_reg << shift_amt);
                g1_next = g1_reg ^ (g2_reg << shift_amt);
            end
        end
    end

    always_comb
    begin
        result_next = result_reg;
        if (ctrl.finish)
        begin
            result_next.no_inverse = 1'b0;
            unique case (ctrl.res_sel)
                bfa_pkg::SEL_XOR:
                begin
                    result_next.value = bfa_pkg::ElemWidth'(u_reg ^ v_reg);
                end
                bfa_pkg::SEL_ACC:
                begin
                    result_next.value = bfa_pkg::ElemWidth'(g1_reg & emask);
                end
                bfa_pkg::SEL_FAIL:
                begin
                    result_next.value      = '0;
                    result_next.no_inverse = 1'b1;
                end
                default:
                begin
                    result_next.value = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg      <= u_next;
        v_reg      <= v_next;
        g1_reg     <= g1_next;
        g2_reg     <= g2_next;
        lu_reg     <= lu_next;
        lv_reg     <= lv_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= ctrl.finish;
        end
    end

    assign stat.mul_last  = cnt_reg >= {1'b0, degree};
    assign stat.cap_hit   = cnt_reg >= {degree, 1'b0};
    assign stat.inv_first = cnt_reg == '0;
    assign stat.u_one     = u_reg == W'(1);
    assign stat.u_zero    = u_reg == '0;

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/binary_field_alu.sv =====
`default_nettype none

// GF(2^m) arithmetic unit, polynomial basis; m and the reduction polynomial
// come from two write-only registers. A request is taken when start is high
// and busy is low; its single result appears on result with done high for
// exactly one cycle and must be captured then, since the receiver cannot
// stall the unit. One request is in flight at a time. Multiply does one
// shift-and-reduce step per cycle. Inverse runs at most 2m Euclid rounds;
// each round finds the operand degrees (ST_INV_LEN) and then updates u, v,
// g1 and g2 in the 64-bit shift-and-xor logic (ST_INV_UPD). Inverse of zero
// or a run hitting the 2m round cap returns value 0 with no_inverse set.
module binary_field_alu #(
    parameter int MAX_DEGREE = 63
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire bfa_pkg::request_t                   request,
    output logic                                     busy,
    output logic                                     done,
    output bfa_pkg::result_t                         result,
    input  wire logic                                cfg_we,
    input  wire bfa_pkg::cfg_index_t                 cfg_index,
    input  wire logic [bfa_pkg::PolyWidth-1:0]       cfg_data
);

    logic [bfa_pkg::DegWidth-1:0]  field_degree_reg;
    logic [bfa_pkg::DegWidth-1:0]  field_degree_next;
    logic [bfa_pkg::PolyWidth-1:0] reduction_poly_reg;
    logic [bfa_pkg::PolyWidth-1:0] reduction_poly_next;
    logic [bfa_pkg::DegWidth-1:0]  degree;

    bfa_pkg::ctrl_t ctrl;
    bfa_pkg::stat_t stat;

    always_comb
    begin
        field_degree_next   = field_degree_reg;
        reduction_poly_next = reduction_poly_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bfa_pkg::CFG_FIELD_DEGREE:
                begin
                    field_degree_next = cfg_data[bfa_pkg::DegWidth-1:0];
                end
                bfa_pkg::CFG_REDUCTION_POLY:
                begin
                    reduction_poly_next = cfg_data;
                end
                default:
                begin
                    field_degree_next = field_degree_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_degree_reg   <= bfa_pkg::DegreeReset;
            reduction_poly_reg <= bfa_pkg::PolyReset;
        end
        else
        begin
            field_degree_reg   <= field_degree_next;
            reduction_poly_reg <= reduction_poly_next;
        end
    end

    assign degree = (field_degree_reg > bfa_pkg::DegWidth'(MAX_DEGREE))
                  ? bfa_pkg::DegWidth'(MAX_DEGREE) : field_degree_reg;

    bfa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (request.cmd),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    bfa_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .degree  (degree),
        .poly    (reduction_poly_reg),
        .ctrl    (ctrl),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the unit busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.no_inverse) |-> (result.value == '0))
        else $error("failed inverse returned a nonzero value");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in flight");
`endif

endmodule

`default_nettype wire
